// ----- hdl/bta_pkg.sv -----
// Package: widths, codes and defaults for the buddy tree allocator.
package bta_pkg;

  localparam int TREE_LEVELS_DEF = 10;
  localparam int TREE_LEVELS_MAX = 12;
  localparam int PSL_RESET       = 10;
  localparam int BSL_RESET       = 10;
  localparam int BLOCK_LOG_MAX   = 16;

  localparam int NODE_W    = 4;
  localparam int PSL_W     = 4;
  localparam int BSL_W     = 5;
  localparam int WANT_W    = 6;
  localparam int REQ_W     = 32;
  localparam int OFF_W     = 26;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_LOG  = 1'b0,
    CFG_BLOCK_LOG = 1'b1
  } cfg_idx_t;

endpackage

// ----- hdl/bta_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module bta_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/buddy_tree_allocator.sv -----
// Binary buddy allocator: tree of free-run levels kept in one RAM, walked one node a cycle.
//
// Requests enter on start/in_* and are taken when busy is low. in_func selects
// allocate (in_request_bytes) or free (in_free_offset). Each request gives one
// result: out_valid is high for one cycle with out_offset_bytes and out_status.
// The receiver cannot stall; the result is simply presented for that cycle.
// The single RAM read port limits the walk to one tree node per cycle on the
// way down and on the way up. One request at a time.
// Configuration: cfg_we/cfg_index/cfg_wdata, written only while idle (the
// user's duty; the block itself does not enforce it). Index 0 sets the pool
// size log from the low four bits of cfg_wdata (values above TREE_LEVELS are
// ignored) and reinitializes the tree; index 1 sets the block size log
// (clipped to 16). Reset and every accepted pool size write start an init sweep
// that rewrites all 2^(TREE_LEVELS+1) RAM entries; busy stays high during it.
module buddy_tree_allocator #(
  parameter int TREE_LEVELS = bta_pkg::TREE_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic [bta_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [bta_pkg::REQ_W-1:0]    in_free_offset,
  output logic                         out_valid,
  output logic [bta_pkg::OFF_W-1:0]    out_offset_bytes,
  output logic [1:0]                   out_status,
  input  logic                         cfg_we,
  input  logic [bta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bta_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int IDX_W  = TREE_LEVELS + 1;
  localparam int DEPTH  = 1 << IDX_W;
  localparam int NODE_W = bta_pkg::NODE_W;
  localparam int PSL_W  = bta_pkg::PSL_W;
  localparam int BSL_W  = bta_pkg::BSL_W;
  localparam int WANT_W = bta_pkg::WANT_W;
  localparam int REQ_W  = bta_pkg::REQ_W;
  localparam int OFF_W  = bta_pkg::OFF_W;
  localparam int PSL_INIT = (bta_pkg::PSL_RESET < TREE_LEVELS) ?
                            bta_pkg::PSL_RESET : TREE_LEVELS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SHIFT, S_A_WANT, S_A_ROOT, S_A_DOWN, S_A_MARK, S_A_UP,
    S_F_CHK, S_F_CLIMB, S_F_MERGE, S_RESP
  } state_t;

  function automatic logic [WANT_W-1:0] bit_len(input logic [REQ_W-1:0] v);
    logic [WANT_W-1:0] r;
    r = '0;
    for (int k = 0; k < REQ_W; k++) begin
      if (v[k]) r = WANT_W'(k + 1);
    end
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] msb_pos(input logic [IDX_W-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int k = 0; k < IDX_W; k++) begin
      if (v[k]) r = NODE_W'(k);
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [PSL_W-1:0]    psl_r, psl_nxt;
  logic [BSL_W-1:0]    bsl_r, bsl_nxt;
  logic                func_r, func_nxt;
  logic [REQ_W-1:0]    opnd_r, opnd_nxt;
  logic [REQ_W-1:0]    shifted_r, shifted_nxt;
  logic [WANT_W-1:0]   want_r, want_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NODE_W-1:0]   lvl_r, lvl_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic                merging_r, merging_nxt;
  logic [IDX_W-1:0]    blk_r, blk_nxt;
  bta_pkg::status_t    st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]    out_offset_r, out_offset_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [NODE_W-1:0]   ram_wdata, ram_rdata;

  logic [NODE_W-1:0]   top_lvl;
  logic [IDX_W-1:0]    cand, nidx, par;
  logic [NODE_W-1:0]   lvl_dec, max_val;
  logic [IDX_W-1:0]    pool_base;

  bta_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    psl_nxt        = psl_r;
    bsl_nxt        = bsl_r;
    func_nxt       = func_r;
    opnd_nxt       = opnd_r;
    shifted_nxt    = shifted_r;
    want_nxt       = want_r;
    idx_nxt        = idx_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    merging_nxt    = merging_r;
    blk_nxt        = blk_r;
    st_nxt         = st_r;
    out_valid_nxt  = 1'b0;
    out_offset_nxt = out_offset_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    top_lvl   = psl_r + NODE_W'(1);
    pool_base = IDX_W'(1) << psl_r;
    cand      = idx_r << 1;
    nidx      = ({2'b00, ram_rdata} < want_r) ? (cand ^ IDX_W'(1)) : cand;
    lvl_dec   = lvl_r - NODE_W'(1);
    par       = idx_r >> 1;
    max_val   = (ram_rdata > cur_r) ? ram_rdata : cur_r;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == '0 || (clr_r >> top_lvl) != '0) begin
          ram_wdata = '0;
        end else begin
          ram_wdata = top_lvl - msb_pos(clr_r);
        end
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          opnd_nxt  = (in_func == bta_pkg::FN_FREE) ? in_free_offset : in_request_bytes;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (func_r == bta_pkg::FN_ALLOC && opnd_r == '0) begin
          st_nxt    = bta_pkg::ST_ZERO;
          state_nxt = S_RESP;
        end else if (func_r == bta_pkg::FN_FREE) begin
          shifted_nxt = opnd_r >> bsl_r;
          state_nxt   = S_F_CHK;
        end else begin
          shifted_nxt = (opnd_r - REQ_W'(1)) >> bsl_r;
          state_nxt   = S_A_WANT;
        end
      end
      S_A_WANT: begin
        want_nxt  = bit_len(shifted_r) + WANT_W'(1);
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(1);
        state_nxt = S_A_ROOT;
      end
      S_A_ROOT: begin
        idx_nxt = IDX_W'(1);
        lvl_nxt = top_lvl;
        if ({2'b00, ram_rdata} < want_r) begin
          st_nxt    = bta_pkg::ST_NOSPACE;
          state_nxt = S_RESP;
        end else if ({2'b00, top_lvl} > want_r) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(2);
          state_nxt = S_A_DOWN;
        end else begin
          state_nxt = S_A_MARK;
        end
      end
      S_A_DOWN: begin
        idx_nxt = nidx;
        lvl_nxt = lvl_dec;
        if ({2'b00, lvl_dec} > want_r) begin
          ram_re    = 1'b1;
          ram_raddr = nidx << 1;
        end else begin
          state_nxt = S_A_MARK;
        end
      end
      S_A_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '0;
        cur_nxt   = '0;
        blk_nxt   = (idx_r << lvl_dec) - pool_base;
        if (idx_r == IDX_W'(1)) begin
          st_nxt    = bta_pkg::ST_OK;
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r ^ IDX_W'(1);
          state_nxt = S_A_UP;
        end
      end
      S_A_UP: begin
        ram_we    = 1'b1;
        ram_waddr = par;
        ram_wdata = max_val;
        idx_nxt   = par;
        cur_nxt   = max_val;
        if (par == IDX_W'(1)) begin
          st_nxt    = bta_pkg::ST_OK;
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = par ^ IDX_W'(1);
        end
      end
      S_F_CHK: begin
        if ((shifted_r >> psl_r) != '0) begin
          st_nxt    = bta_pkg::ST_BADFREE;
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = shifted_r[IDX_W-1:0] + pool_base;
          lvl_nxt   = NODE_W'(1);
          ram_re    = 1'b1;
          ram_raddr = shifted_r[IDX_W-1:0] + pool_base;
          state_nxt = S_F_CLIMB;
        end
      end
      S_F_CLIMB: begin
        if (ram_rdata != '0) begin
          idx_nxt = par;
          lvl_nxt = lvl_r + NODE_W'(1);
          if (par == '0) begin
            st_nxt    = bta_pkg::ST_BADFREE;
            state_nxt = S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = par;
          end
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = idx_r;
          ram_wdata   = lvl_r;
          cur_nxt     = lvl_r;
          merging_nxt = 1'b1;
          if (idx_r == IDX_W'(1)) begin
            st_nxt    = bta_pkg::ST_OK;
            state_nxt = S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r ^ IDX_W'(1);
            state_nxt = S_F_MERGE;
          end
        end
      end
      S_F_MERGE: begin
        if ((merging_r && ram_rdata == lvl_r) || cur_r > ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = par;
          idx_nxt   = par;
          if (merging_r && ram_rdata == lvl_r) begin
            lvl_nxt   = lvl_r + NODE_W'(1);
            cur_nxt   = lvl_r + NODE_W'(1);
            ram_wdata = lvl_r + NODE_W'(1);
          end else begin
            ram_wdata   = cur_r;
            merging_nxt = 1'b0;
          end
          if (par == IDX_W'(1)) begin
            st_nxt    = bta_pkg::ST_OK;
            state_nxt = S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = par ^ IDX_W'(1);
          end
        end else begin
          st_nxt    = bta_pkg::ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = st_r;
        if (st_r == bta_pkg::ST_OK && func_r == bta_pkg::FN_ALLOC) begin
          out_offset_nxt = OFF_W'(REQ_W'(blk_r) << bsl_r);
        end else begin
          out_offset_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        bta_pkg::CFG_POOL_LOG: begin
          if (cfg_wdata[PSL_W-1:0] <= PSL_W'(TREE_LEVELS)) begin
            psl_nxt   = cfg_wdata[PSL_W-1:0];
            clr_nxt   = '0;
            state_nxt = S_INIT;
          end
        end
        bta_pkg::CFG_BLOCK_LOG: begin
          bsl_nxt = (cfg_wdata > BSL_W'(bta_pkg::BLOCK_LOG_MAX)) ?
                    BSL_W'(bta_pkg::BLOCK_LOG_MAX) : cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      psl_r       <= PSL_W'(PSL_INIT);
      bsl_r       <= BSL_W'(bta_pkg::BSL_RESET);
      out_valid_r <= 1'b0;
      merging_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      psl_r        <= psl_nxt;
      bsl_r        <= bsl_nxt;
      out_valid_r  <= out_valid_nxt;
      merging_r    <= merging_nxt;
      func_r       <= func_nxt;
      opnd_r       <= opnd_nxt;
      shifted_r    <= shifted_nxt;
      want_r       <= want_nxt;
      idx_r        <= idx_nxt;
      lvl_r        <= lvl_nxt;
      cur_r        <= cur_nxt;
      blk_r        <= blk_nxt;
      st_r         <= st_nxt;
      out_offset_r <= out_offset_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_offset_bytes = out_offset_r;
  assign out_status       = out_status_r;

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> busy)
    else $error("request accepted without going busy");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("tree read and write hit the same node in one cycle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!ram_we && !out_valid_nxt))
    else $error("tree write or result while idle");

  a_err_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bta_pkg::ST_OK) |-> (out_offset_bytes == '0))
    else $error("nonzero offset on failed request");

endmodule
